FILE: rtl/nec_ir_pulse_decoder_assert.svh
// Assertion macros used by the NEC infrared decoder core.
`ifndef NEC_IR_PULSE_DECODER_ASSERT_SVH
`define NEC_IR_PULSE_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NEC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/nec_ir_pkg.sv
// Package with the types, constants and helper functions of the NEC infrared decoder.
package nec_ir_pkg;

  localparam int FRAME_BITS = 32;
  localparam int WIDTH_BITS = 18;

  localparam int BIT_CNT_W = $clog2(FRAME_BITS + 1);
  localparam int FRAME_IDX_W = $clog2(FRAME_BITS);
  localparam int CMD_SHIFT = (FRAME_BITS >= 16) ? (FRAME_BITS - 16) : 0;
  localparam int INV_SHIFT = (FRAME_BITS >= 8) ? (FRAME_BITS - 8) : 0;

  localparam int STEP_W = 16;
  localparam int RELEASE_W = 18;
  localparam int HOLD_STEP_W = 10;
  localparam int CAPTURE_W = 16;
  localparam int HOLD_W = 16;
  localparam int CFG_DATA_W = 18;
  localparam int CMP_W = (WIDTH_BITS > RELEASE_W) ? WIDTH_BITS : RELEASE_W;

  typedef logic [WIDTH_BITS-1:0] width_t;
  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [BIT_CNT_W-1:0] bit_cnt_t;

  localparam width_t WIDTH_MAX = {WIDTH_BITS{1'b1}};

  localparam width_t LDR_LOW_MIN = width_t'(8000);
  localparam width_t LDR_LOW_MAX = width_t'(10000);
  localparam width_t LDR_HIGH_MIN = width_t'(4000);
  localparam width_t LDR_HIGH_MAX = width_t'(6000);
  localparam width_t RPT_HIGH_MIN = width_t'(2000);
  localparam width_t RPT_HIGH_MAX = width_t'(2500);
  localparam width_t BIT_LOW_MIN = width_t'(500);
  localparam width_t BIT_LOW_MAX = width_t'(620);
  localparam width_t ZERO_HIGH_MIN = width_t'(505);
  localparam width_t ZERO_HIGH_MAX = width_t'(625);
  localparam width_t ONE_HIGH_MIN = width_t'(1500);
  localparam width_t ONE_HIGH_MAX = width_t'(1880);

  localparam logic [STEP_W-1:0] OVERFLOW_STEP_RESET = STEP_W'(60000);
  localparam logic [RELEASE_W-1:0] RELEASE_LIMIT_RESET = RELEASE_W'(108000);
  localparam logic [HOLD_STEP_W-1:0] HOLD_STEP_RESET = HOLD_STEP_W'(108);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_RISE = 2'd1,
    OP_FALL = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_OVERFLOW_STEP = 2'd0,
    REG_RELEASE_LIMIT = 2'd1,
    REG_HOLD_STEP = 2'd2,
    REG_UNUSED = 2'd3
  } reg_index_t;

  typedef struct packed {
    op_t op;
    logic pin_high;
    logic [CAPTURE_W-1:0] capture_us;
  } event_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic key_pressed;
    logic key_went_down;
    logic key_went_up;
    logic [HOLD_W-1:0] hold_time_ms;
  } key_t;

  typedef struct packed {
    logic [STEP_W-1:0] overflow_step_us;
    logic [RELEASE_W-1:0] release_limit_us;
    logic [HOLD_STEP_W-1:0] hold_step_ms;
  } cfg_t;

  function automatic width_t sat_width(width_t a, logic [STEP_W-1:0] b);
    logic [WIDTH_BITS:0] s;
    s = {1'b0, a} + {{(WIDTH_BITS + 1 - STEP_W){1'b0}}, b};
    return s[WIDTH_BITS] ? WIDTH_MAX : s[WIDTH_BITS-1:0];
  endfunction

  function automatic logic in_window(width_t v, width_t lo, width_t hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic [7:0] frame_byte_at(frame_t f, logic at_inverse);
    logic [FRAME_BITS+7:0] ext;
    ext = {8'h00, f};
    return at_inverse ? ext[INV_SHIFT +: 8] : ext[CMD_SHIFT +: 8];
  endfunction

endpackage

FILE: rtl/nec_ir_cfg.sv
// Configuration registers of the NEC infrared decoder.
module nec_ir_cfg
  import nec_ir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  reg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.overflow_step_us <= OVERFLOW_STEP_RESET;
      cfg.release_limit_us <= RELEASE_LIMIT_RESET;
      cfg.hold_step_ms <= HOLD_STEP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OVERFLOW_STEP: cfg.overflow_step_us <= cfg_data[STEP_W-1:0];
        REG_RELEASE_LIMIT: cfg.release_limit_us <= cfg_data[RELEASE_W-1:0];
        REG_HOLD_STEP:     cfg.hold_step_ms <= cfg_data[HOLD_STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/nec_ir_core.sv
// Decoder state and the next-state logic that applies one event beat.
module nec_ir_core
  import nec_ir_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   fire,
  input  event_t item,
  input  cfg_t   cfg,
  output key_t   result
);

  `include "nec_ir_pulse_decoder_assert.svh"

  typedef enum logic [1:0] {
    MODE_LEADER = 2'd0,
    MODE_DATA = 2'd1,
    MODE_STOP = 2'd2
  } mode_t;

  mode_t mode, mode_next;
  width_t low_width, low_width_next;
  width_t high_width, high_width_next;
  bit_cnt_t bit_count, bit_count_next;
  frame_t frame_bits, frame_bits_next;
  logic [7:0] code_reg, code_reg_next;
  logic press_flag, press_flag_next;
  logic down_flag, down_flag_next;
  logic up_flag, up_flag_next;
  logic [HOLD_W-1:0] hold_reg, hold_reg_next;

  width_t high_sum;
  logic [HOLD_W:0] hold_sum;
  logic [7:0] cmd_byte;
  logic [7:0] inv_byte;
  logic high_below_limit;

  always_comb begin
    high_sum = sat_width(high_width, item.capture_us);
    hold_sum = {1'b0, hold_reg} + (HOLD_W + 1)'(cfg.hold_step_ms);
    high_below_limit = CMP_W'(high_width) < CMP_W'(cfg.release_limit_us);

    mode_next = mode;
    low_width_next = low_width;
    high_width_next = high_width;
    bit_count_next = bit_count;
    frame_bits_next = frame_bits;
    code_reg_next = code_reg;
    press_flag_next = press_flag;
    down_flag_next = down_flag;
    up_flag_next = up_flag;
    hold_reg_next = hold_reg;
    cmd_byte = 8'h00;
    inv_byte = 8'h00;

    unique case (item.op)
      OP_TICK: begin
        if (high_below_limit) begin
          if (item.pin_high) begin
            high_width_next = sat_width(high_width, cfg.overflow_step_us);
          end else begin
            low_width_next = sat_width(low_width, cfg.overflow_step_us);
          end
        end else if (item.pin_high && press_flag) begin
          press_flag_next = 1'b0;
          up_flag_next = 1'b1;
        end
      end
      OP_RISE: begin
        low_width_next = sat_width(low_width, item.capture_us);
        high_width_next = '0;
      end
      OP_FALL: begin
        high_width_next = high_sum;
        low_width_next = '0;
        mode_next = MODE_LEADER;
        unique case (mode)
          MODE_DATA: begin
            if (in_window(low_width, BIT_LOW_MIN, BIT_LOW_MAX)) begin
              if (in_window(high_sum, ZERO_HIGH_MIN, ZERO_HIGH_MAX)) begin
                bit_count_next = bit_count + 1'b1;
                mode_next = MODE_DATA;
              end else if (in_window(high_sum, ONE_HIGH_MIN, ONE_HIGH_MAX)) begin
                frame_bits_next[bit_count[FRAME_IDX_W-1:0]] = 1'b1;
                bit_count_next = bit_count + 1'b1;
                mode_next = MODE_DATA;
              end
              cmd_byte = frame_byte_at(frame_bits_next, 1'b0);
              inv_byte = frame_byte_at(frame_bits_next, 1'b1);
              if (bit_count_next == BIT_CNT_W'(FRAME_BITS)) begin
                if ((cmd_byte ^ inv_byte) == 8'hFF) begin
                  code_reg_next = cmd_byte;
                  press_flag_next = 1'b1;
                  down_flag_next = 1'b1;
                  hold_reg_next = HOLD_W'(cfg.hold_step_ms);
                end else begin
                  code_reg_next = 8'h00;
                  press_flag_next = 1'b0;
                  down_flag_next = 1'b0;
                  hold_reg_next = '0;
                end
                mode_next = MODE_STOP;
              end
            end
          end
          MODE_STOP: begin
            mode_next = MODE_LEADER;
          end
          default: begin
            if (in_window(low_width, LDR_LOW_MIN, LDR_LOW_MAX)) begin
              if (in_window(high_sum, LDR_HIGH_MIN, LDR_HIGH_MAX)) begin
                bit_count_next = '0;
                frame_bits_next = '0;
                mode_next = MODE_DATA;
              end else if (in_window(high_sum, RPT_HIGH_MIN, RPT_HIGH_MAX)) begin
                hold_reg_next = hold_sum[HOLD_W] ? {HOLD_W{1'b1}} : hold_sum[HOLD_W-1:0];
                mode_next = MODE_STOP;
              end
            end
            if (mode_next != MODE_STOP && press_flag) begin
              press_flag_next = 1'b0;
              up_flag_next = 1'b1;
            end
          end
        endcase
      end
      OP_READ: begin
        down_flag_next = 1'b0;
        if (up_flag) begin
          up_flag_next = 1'b0;
          code_reg_next = 8'h00;
        end
      end
      default: begin
      end
    endcase

    if (item.op == OP_READ) begin
      result.key_code = code_reg;
      result.key_pressed = press_flag;
      result.key_went_down = down_flag;
      result.key_went_up = up_flag;
      result.hold_time_ms = hold_reg;
    end else begin
      result.key_code = code_reg_next;
      result.key_pressed = press_flag_next;
      result.key_went_down = down_flag_next;
      result.key_went_up = up_flag_next;
      result.hold_time_ms = hold_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_LEADER;
      low_width <= '0;
      high_width <= '0;
      bit_count <= '0;
      frame_bits <= '0;
      code_reg <= 8'h00;
      press_flag <= 1'b0;
      down_flag <= 1'b0;
      up_flag <= 1'b0;
      hold_reg <= '0;
    end else if (fire) begin
      mode <= mode_next;
      low_width <= low_width_next;
      high_width <= high_width_next;
      bit_count <= bit_count_next;
      frame_bits <= frame_bits_next;
      code_reg <= code_reg_next;
      press_flag <= press_flag_next;
      down_flag <= down_flag_next;
      up_flag <= up_flag_next;
      hold_reg <= hold_reg_next;
    end
  end

  `NEC_ASSERT_SAME(a_press_from_fall, clk, rst, $rose(press_flag), $past(fire) && $past(item.op) == OP_FALL, "Key press was raised without a falling edge.")
  `NEC_ASSERT_SAME(a_up_with_release, clk, rst, $rose(up_flag), $fell(press_flag), "Key release was flagged without the key being dropped.")
  `NEC_ASSERT_SAME(a_data_count, clk, rst, mode == MODE_DATA, bit_count < BIT_CNT_W'(FRAME_BITS), "Data mode holds a full bit count.")
  `NEC_ASSERT_NEXT(a_idle_holds, clk, rst, !fire, $stable(mode) && $stable(frame_bits) && $stable(low_width) && $stable(high_width), "Decoder state changed without an event.")

endmodule

FILE: rtl/nec_ir_pulse_decoder.sv
// Top level of the NEC infrared decoder: event register, decoder core and result register.
//
//   Channel  Signals                            Beat
//   event    event_valid, event_stall, event_data  one pulse event or key read
//   key      key_valid, key_stall, key_data        one key snapshot per event
//   config   cfg_write, cfg_index, cfg_data        one register write
//
// One event beat is taken every cycle while key_stall does not hold back the result register.
// The event register feeds the decoder logic, whose snapshot is written into the result register.
// A synchronous rst clears the decoder state and both registers' valid bits, and resets the configuration.
// While key_stall holds a result, one further event waits in the event register.
module nec_ir_pulse_decoder
  import nec_ir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  event_valid,
  output logic                  event_stall,
  input  event_t                event_data,
  output logic                  key_valid,
  input  logic                  key_stall,
  output key_t                  key_data,
  input  logic                  cfg_write,
  input  reg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic hold_valid;
  event_t hold_item;
  logic advance;
  logic accept;
  cfg_t cfg;
  key_t result;

  assign advance = hold_valid && (!key_valid || !key_stall);
  assign event_stall = hold_valid && !advance;
  assign accept = event_valid && !event_stall;

  nec_ir_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  nec_ir_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (hold_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
    if (accept) begin
      hold_item <= event_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (advance) begin
      key_valid <= 1'b1;
    end else if (!key_stall) begin
      key_valid <= 1'b0;
    end
    if (advance) begin
      key_data <= result;
    end
  end

endmodule

FILE: verif/tb_nec_ir_pulse_decoder.sv
// Self-checking testbench for the NEC infrared decoder: drives pulse events, checks key beats.
`timescale 1ns / 1ps

module tb_nec_ir_pulse_decoder;
  import nec_ir_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 100;

  typedef enum logic [1:0] {
    DM_LEADER = 2'd0,
    DM_DATA = 2'd1,
    DM_STOP = 2'd2,
    DM_SPARE = 2'd3
  } decode_mode_t;

  typedef enum int {
    FRAME_CLEAN,
    FRAME_BAD_INVERSE,
    FRAME_CUT
  } frame_kind_t;

  class key_snapshot_board;
    logic [STEP_W-1:0] step_us;
    logic [RELEASE_W-1:0] release_us;
    logic [HOLD_STEP_W-1:0] hold_step;
    decode_mode_t mode;
    width_t low_w;
    width_t high_w;
    logic [5:0] bits_seen;
    frame_t frame;
    logic [7:0] code;
    logic pressed;
    logic went_down;
    logic went_up;
    logic [HOLD_W-1:0] hold_ms;
    key_t snapshots_due[$];
    int errors;
    int checked;
    int frames_taken;
    int frames_refused;
    int repeats_seen;
    int releases;

    function new();
      step_us = OVERFLOW_STEP_RESET;
      release_us = RELEASE_LIMIT_RESET;
      hold_step = HOLD_STEP_RESET;
      mode = DM_LEADER;
      low_w = '0;
      high_w = '0;
      bits_seen = '0;
      frame = '0;
      code = '0;
      pressed = 1'b0;
      went_down = 1'b0;
      went_up = 1'b0;
      hold_ms = '0;
      errors = 0;
      checked = 0;
      frames_taken = 0;
      frames_refused = 0;
      repeats_seen = 0;
      releases = 0;
    endfunction

    function void set_register(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_OVERFLOW_STEP: step_us = value[STEP_W-1:0];
        REG_RELEASE_LIMIT: release_us = value[RELEASE_W-1:0];
        REG_HOLD_STEP: hold_step = value[HOLD_STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function width_t add_sat(width_t a, logic [CAPTURE_W-1:0] b);
      int unsigned s;
      s = int'(a) + int'(b);
      return (s > WIDTH_MAX) ? WIDTH_MAX : width_t'(s);
    endfunction

    function bit fits(width_t v, width_t lo, width_t hi);
      return (v >= lo) && (v <= hi);
    endfunction

    function void let_go_key();
      if (pressed) begin
        pressed = 1'b0;
        went_up = 1'b1;
        releases++;
      end
    endfunction

    function void judge_fall();
      logic [7:0] cmd;
      logic [7:0] inv;
      int unsigned sum;
      case (mode)
        DM_DATA: begin
          mode = DM_LEADER;
          if (fits(low_w, BIT_LOW_MIN, BIT_LOW_MAX)) begin
            if (fits(high_w, ZERO_HIGH_MIN, ZERO_HIGH_MAX)) begin
              bits_seen++;
              mode = DM_DATA;
            end else if (fits(high_w, ONE_HIGH_MIN, ONE_HIGH_MAX)) begin
              frame[bits_seen[FRAME_IDX_W-1:0]] = 1'b1;
              bits_seen++;
              mode = DM_DATA;
            end
            if (bits_seen == FRAME_BITS) begin
              cmd = frame[CMD_SHIFT +: 8];
              inv = frame[INV_SHIFT +: 8];
              if ((cmd ^ inv) == 8'hFF) begin
                code = cmd;
                pressed = 1'b1;
                went_down = 1'b1;
                hold_ms = HOLD_W'(hold_step);
                frames_taken++;
              end else begin
                code = '0;
                pressed = 1'b0;
                went_down = 1'b0;
                hold_ms = '0;
                frames_refused++;
              end
              mode = DM_STOP;
            end
          end
        end
        DM_STOP: mode = DM_LEADER;
        default: begin
          mode = DM_LEADER;
          if (fits(low_w, LDR_LOW_MIN, LDR_LOW_MAX)) begin
            if (fits(high_w, LDR_HIGH_MIN, LDR_HIGH_MAX)) begin
              bits_seen = '0;
              frame = '0;
              mode = DM_DATA;
            end else if (fits(high_w, RPT_HIGH_MIN, RPT_HIGH_MAX)) begin
              sum = int'(hold_ms) + int'(hold_step);
              hold_ms = (sum > 65535) ? 16'hFFFF : HOLD_W'(sum);
              mode = DM_STOP;
              repeats_seen++;
            end
          end
          if (mode != DM_STOP) let_go_key();
        end
      endcase
      low_w = '0;
    endfunction

    function void note_event(event_t ev);
      key_t snap;
      case (ev.op)
        OP_TICK: begin
          if (high_w < release_us) begin
            if (ev.pin_high) high_w = add_sat(high_w, step_us);
            else low_w = add_sat(low_w, step_us);
          end else if (ev.pin_high) begin
            let_go_key();
          end
        end
        OP_RISE: begin
          low_w = add_sat(low_w, ev.capture_us);
          high_w = '0;
        end
        OP_FALL: begin
          high_w = add_sat(high_w, ev.capture_us);
          judge_fall();
        end
        default: ;
      endcase
      snap.key_code = code;
      snap.key_pressed = pressed;
      snap.key_went_down = went_down;
      snap.key_went_up = went_up;
      snap.hold_time_ms = hold_ms;
      snapshots_due.push_back(snap);
      if (ev.op == OP_READ) begin
        went_down = 1'b0;
        if (went_up) begin
          went_up = 1'b0;
          code = '0;
        end
      end
    endfunction

    task report(input string msg);
      if (errors < PRINT_LIMIT) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_key(input key_t got);
      key_t want;
      if (snapshots_due.size() == 0) begin
        report($sformatf("key beat %0d arrived with no event outstanding", checked));
      end else begin
        want = snapshots_due.pop_front();
        if (got.key_code !== want.key_code)
          report($sformatf("beat %0d key_code got %0h want %0h", checked, got.key_code,
                           want.key_code));
        if (got.key_pressed !== want.key_pressed)
          report($sformatf("beat %0d key_pressed got %0b want %0b", checked, got.key_pressed,
                           want.key_pressed));
        if (got.key_went_down !== want.key_went_down)
          report($sformatf("beat %0d key_went_down got %0b want %0b", checked,
                           got.key_went_down, want.key_went_down));
        if (got.key_went_up !== want.key_went_up)
          report($sformatf("beat %0d key_went_up got %0b want %0b", checked, got.key_went_up,
                           want.key_went_up));
        if (got.hold_time_ms !== want.hold_time_ms)
          report($sformatf("beat %0d hold_time_ms got %0d want %0d", checked, got.hold_time_ms,
                           want.hold_time_ms));
      end
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic event_valid = 1'b0;
  logic event_stall;
  event_t event_data = '0;
  logic key_valid;
  logic key_stall = 1'b0;
  key_t key_data;
  logic cfg_write = 1'b0;
  reg_index_t cfg_index = REG_OVERFLOW_STEP;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  key_snapshot_board record;
  bit sender_eager = 1'b0;
  bit receiver_eager = 1'b0;
  int key_hold_off = 0;
  int events_sent = 0;
  int settings_used = 0;
  int cycle_count = 0;

  nec_ir_pulse_decoder dut (
    .clk(clk),
    .rst(rst),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .event_data(event_data),
    .key_valid(key_valid),
    .key_stall(key_stall),
    .key_data(key_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_nec_ir_pulse_decoder NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && key_valid && !key_stall) begin
      record.check_key(key_data);
      key_hold_off = receiver_eager ? 0 : $urandom_range(7, 0);
    end else if (key_hold_off != 0) begin
      key_hold_off--;
    end
  end

  always @(negedge clk) key_stall <= (key_hold_off != 0);

  function automatic event_t make_event(input op_t op, input logic pin,
                                        input logic [CAPTURE_W-1:0] cap);
    event_t ev;
    ev.op = op;
    ev.pin_high = pin;
    ev.capture_us = cap;
    return ev;
  endfunction

  function automatic logic [CAPTURE_W-1:0] pick_width(input int lo, input int hi);
    case ($urandom_range(5, 0))
      0: return CAPTURE_W'(lo);
      1: return CAPTURE_W'(hi);
      default: return CAPTURE_W'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [CAPTURE_W-1:0] miss_width(input int lo, input int hi);
    return $urandom_range(1, 0) ? CAPTURE_W'(lo - 1) : CAPTURE_W'(hi + 1);
  endfunction

  task automatic send_event(input event_t ev);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(7, 0);
    @(negedge clk);
    if (gap != 0) begin
      event_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    event_valid <= 1'b1;
    event_data <= ev;
    do @(posedge clk); while (event_stall);
    record.note_event(ev);
    events_sent++;
  endtask

  task automatic send_tick(input logic pin);
    send_event(make_event(OP_TICK, pin, CAPTURE_W'($urandom)));
  endtask

  task automatic send_rise(input logic [CAPTURE_W-1:0] cap);
    send_event(make_event(OP_RISE, 1'($urandom_range(1, 0)), cap));
  endtask

  task automatic send_fall(input logic [CAPTURE_W-1:0] cap);
    send_event(make_event(OP_FALL, 1'($urandom_range(1, 0)), cap));
  endtask

  task automatic send_read();
    send_event(make_event(OP_READ, 1'($urandom_range(1, 0)), CAPTURE_W'($urandom)));
  endtask

  task automatic drain();
    @(negedge clk);
    event_valid <= 1'b0;
    while (record.snapshots_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    record.set_register(idx, value);
  endtask

  task automatic apply_settings(input logic [STEP_W-1:0] step,
                                input logic [RELEASE_W-1:0] limit,
                                input logic [HOLD_STEP_W-1:0] hold, input bit poke_spare);
    drain();
    write_register(REG_OVERFLOW_STEP, CFG_DATA_W'(step));
    write_register(REG_RELEASE_LIMIT, CFG_DATA_W'(limit));
    write_register(REG_HOLD_STEP, CFG_DATA_W'(hold));
    if (poke_spare) write_register(REG_UNUSED, CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0] cmd;
    logic [7:0] inv;
    logic [31:0] word;
    int cut_at;
    int lead_low;
    int ticks;
    cmd = 8'($urandom);
    inv = ~cmd;
    if (kind == FRAME_BAD_INVERSE) inv = inv ^ 8'($urandom_range(255, 1));
    word = {inv, cmd, 16'($urandom)};
    cut_at = (kind == FRAME_CUT) ? $urandom_range(FRAME_BITS - 1, 0) : FRAME_BITS;
    lead_low = pick_width(8000, 10000);
    ticks = 0;
    if (record.step_us <= lead_low && $urandom_range(3, 0) == 0)
      ticks = $urandom_range((lead_low / record.step_us > 2) ? 2 : lead_low / record.step_us, 0);
    repeat (ticks) send_tick(1'b0);
    send_rise(CAPTURE_W'(lead_low - ticks * record.step_us));
    send_fall(pick_width(4000, 6000));
    for (int i = 0; i < FRAME_BITS; i++) begin
      if (i == cut_at && $urandom_range(1, 0)) send_rise(miss_width(500, 620));
      else send_rise(pick_width(500, 620));
      if (i == cut_at)
        send_fall(word[i] ? miss_width(1500, 1880) : miss_width(505, 625));
      else
        send_fall(word[i] ? pick_width(1500, 1880) : pick_width(505, 625));
      if (i == cut_at) break;
    end
    send_rise(pick_width(500, 620));
    send_fall(pick_width(0, 2000));
  endtask

  task automatic send_repeat(input bit short_form);
    send_rise(pick_width(8000, 10000));
    send_fall(pick_width(2000, 2500));
    if (!short_form) send_rise(pick_width(500, 620));
    send_fall(pick_width(0, 1000));
  endtask

  task automatic hold_pin_high();
    repeat ($urandom_range(6, 1)) send_tick(1'b1);
  endtask

  task automatic run_phase(input int budget);
    int start;
    int pick;
    start = events_sent;
    while (events_sent - start < budget) begin
      sender_eager = ($urandom_range(3, 0) == 0);
      receiver_eager = ($urandom_range(3, 0) == 0);
      pick = $urandom_range(99, 0);
      if (pick < 45) begin
        send_frame(FRAME_CLEAN);
        repeat ($urandom_range(3, 0)) send_repeat($urandom_range(1, 0));
        if ($urandom_range(1, 0)) hold_pin_high();
        if ($urandom_range(1, 0)) send_read();
      end else if (pick < 55) begin
        send_frame(FRAME_BAD_INVERSE);
      end else if (pick < 63) begin
        send_frame(FRAME_CUT);
      end else if (pick < 72) begin
        send_repeat($urandom_range(1, 0));
      end else if (pick < 82) begin
        repeat ($urandom_range(3, 1)) send_read();
      end else begin
        repeat ($urandom_range(4, 1))
          send_event(make_event(op_t'($urandom_range(3, 0)), 1'($urandom_range(1, 0)),
                                CAPTURE_W'($urandom)));
      end
    end
  endtask

  task automatic directed_checks();
    send_read();
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_rise(16'hFFFF);
    repeat (4) send_tick(1'b0);
    send_fall(16'hFFFF);
    send_rise(16'd9000);
    send_fall(16'd4500);
    send_fall(16'd0);
    send_rise(16'd10000);
    send_fall(16'd6000);
    send_fall(16'd0);
    send_rise(16'd7999);
    send_fall(16'd4000);
    send_rise(16'd8000);
    send_fall(16'd2000);
    send_fall(16'd0);
    send_read();
  endtask

  initial begin
    record = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_checks();

    apply_settings(16'd60000, 18'd108000, 10'd108, 1'b0);
    run_phase(70);
    drain();
    run_phase(60);

    apply_settings(16'd65535, 18'd262143, 10'd1023, 1'b1);
    sender_eager = 1'b0;
    send_rise(16'd0);
    repeat (6) send_tick(1'b1);
    send_fall(16'hFFFF);
    repeat (66) send_repeat(1'b1);
    run_phase(40);

    apply_settings(16'd1, 18'd1, 10'd1, 1'b0);
    run_phase(60);

    repeat (2) begin
      apply_settings(16'($urandom_range(65535, 1)), 18'($urandom_range(262143, 1)),
                     10'($urandom_range(1023, 1)), 1'b0);
      run_phase(40);
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Run covered %0d events and %0d key beats across %0d register settings.",
             events_sent, record.checked, settings_used);
    $display("Frames decoded %0d, refused %0d, repeat codes %0d, key releases %0d.",
             record.frames_taken, record.frames_refused, record.repeats_seen, record.releases);
    if (record.errors == 0) begin
      $display("tb_nec_ir_pulse_decoder OK");
    end else begin
      $display("tb_nec_ir_pulse_decoder NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/nec_ir_pkg.sv
rtl/nec_ir_cfg.sv
rtl/nec_ir_core.sv
rtl/nec_ir_pulse_decoder.sv
verif/tb_nec_ir_pulse_decoder.sv
